>>> src/s16alu_pkg.sv
// shared types, codes and widths of the s16 integer alu
`timescale 1ns / 1ps
`default_nettype none

package s16alu_pkg;

	// data path widths
	localparam int DATA_W        = 16;
	localparam int WIDE_W        = 32;
	localparam int BITS_W        = 64;
	localparam int TYPE_W        = 4;
	localparam int MOD_W         = 3;
	localparam int DIV_STEPS_DEF = 4;

	// operation codes
	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_MAD  = 4'd3,
		OP_SAD  = 4'd4,
		OP_DIV  = 4'd5,
		OP_REM  = 4'd6,
		OP_ABS  = 4'd7,
		OP_NEG  = 4'd8,
		OP_MIN  = 4'd9,
		OP_MAX  = 4'd10,
		OP_CVT  = 4'd11,
		OP_SELP = 4'd12,
		OP_SETP = 4'd13
	} op_t;

	// mul / mad forms
	localparam logic [MOD_W-1:0] MD_HI   = 3'd0;
	localparam logic [MOD_W-1:0] MD_LO   = 3'd1;
	localparam logic [MOD_W-1:0] MD_WIDE = 3'd2;

	// setp compare codes
	localparam logic [MOD_W-1:0] CMP_EQ = 3'd0;
	localparam logic [MOD_W-1:0] CMP_NE = 3'd1;
	localparam logic [MOD_W-1:0] CMP_LT = 3'd2;
	localparam logic [MOD_W-1:0] CMP_LE = 3'd3;
	localparam logic [MOD_W-1:0] CMP_GT = 3'd4;
	localparam logic [MOD_W-1:0] CMP_GE = 3'd5;

	// result type tags, also the cvt target codes
	localparam logic [TYPE_W-1:0] TY_S16  = 4'd0;
	localparam logic [TYPE_W-1:0] TY_S32  = 4'd1;
	localparam logic [TYPE_W-1:0] TY_U8   = 4'd2;
	localparam logic [TYPE_W-1:0] TY_U16  = 4'd3;
	localparam logic [TYPE_W-1:0] TY_U32  = 4'd4;
	localparam logic [TYPE_W-1:0] TY_U64  = 4'd5;
	localparam logic [TYPE_W-1:0] TY_S8   = 4'd6;
	localparam logic [TYPE_W-1:0] TY_S64  = 4'd7;
	localparam logic [TYPE_W-1:0] TY_PRED = 4'd8;

	// status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_MOD  = 2'd1,
		ST_DIV_ZERO = 2'd2
	} status_t;

	// payload that travels down the pipeline
	typedef struct packed {
		op_t                      op;
		logic [MOD_W-1:0]         md;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic signed [DATA_W-1:0] c;
		logic signed [WIDE_W-1:0] prod;
		logic [DATA_W-1:0]        rem;
		logic [DATA_W-1:0]        quo;
		logic [DATA_W-1:0]        dvs;
		logic                     qneg;
		logic                     rneg;
	} pipe_t;

endpackage

`default_nettype wire

>>> src/s16alu_ifs.sv
// command and result channel interfaces of the s16 integer alu
`timescale 1ns / 1ps
`default_nettype none

interface s16alu_cmd_if import s16alu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [3:0]               operation;
	logic [MOD_W-1:0]         modifier;
	logic signed [DATA_W-1:0] operand_a;
	logic signed [DATA_W-1:0] operand_b;
	logic signed [DATA_W-1:0] operand_c;

	modport source (output valid, operation, modifier, operand_a, operand_b, operand_c,
		input ready);
	modport sink (input valid, operation, modifier, operand_a, operand_b, operand_c,
		output ready);
endinterface

interface s16alu_res_if import s16alu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BITS_W-1:0] result_bits;
	logic [TYPE_W-1:0] result_type;
	logic [1:0]        status;

	modport source (output valid, result_bits, result_type, status, input ready);
	modport sink (input valid, result_bits, result_type, status, output ready);
endinterface

`default_nettype wire

>>> src/s16_integer_alu_top.sv
// top level of the signed 16-bit integer alu
//
// cmd channel: one instruction per beat (operation, modifier, three signed
// 16-bit operands). res channel: one result per beat (64-bit bit pattern,
// type tag, status). both use valid/ready; a beat moves when both are high.
// every instruction gives exactly one result, in issue order.
// path: the decode register, a chain of restoring divider stages that each
// retire DIV_STEPS quotient bits (4 at the default), and the output
// register, the same for every operation. throughput: one instruction per
// cycle while the receiver is ready.
// each stage holds its own valid bit and takes a beat when it is empty or
// drains downstream, so a stalled receiver fills the bubbles first and then
// holds every stage; nothing is dropped or repeated.
// reset clears only the valid bits. division by zero, unknown operations
// and bad mul/mad/setp modifiers give a zero pattern and a status.
`timescale 1ns / 1ps
`default_nettype none

module s16_integer_alu_top import s16alu_pkg::*; #(
	parameter int DIV_STEPS = DIV_STEPS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	s16alu_cmd_if.sink   cmd,
	s16alu_res_if.source res
);

	localparam int NSTG = DATA_W / DIV_STEPS;

	logic  stg_valid [0:NSTG];
	logic  stg_ready [0:NSTG];
	pipe_t stg_data  [0:NSTG];

	// operand capture and product
	s16alu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.valid_o (stg_valid[0]),
		.ready_i (stg_ready[0]),
		.data_o  (stg_data[0])
	);

	// divider stage chain
	for (genvar g = 0; g < NSTG; g++) begin : g_div
		s16alu_div_stage #(
			.DIV_STEPS (DIV_STEPS)
		) u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (stg_valid[g]),
			.ready_o (stg_ready[g]),
			.data_i  (stg_data[g]),
			.valid_o (stg_valid[g+1]),
			.ready_i (stg_ready[g+1]),
			.data_o  (stg_data[g+1])
		);
	end

	// result select and output register
	s16alu_format u_format (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (stg_valid[NSTG]),
		.ready_o (stg_ready[NSTG]),
		.data_i  (stg_data[NSTG]),
		.res     (res)
	);

endmodule

`default_nettype wire

>>> src/s16alu_decode.sv
// first stage: operand capture, 16x16 product and divider setup
`timescale 1ns / 1ps
`default_nettype none

module s16alu_decode import s16alu_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	s16alu_cmd_if.sink   cmd,
	output logic         valid_o,
	input  wire logic    ready_i,
	output pipe_t        data_o
);

	logic                     valid_s1;
	pipe_t                    pipe_s1;
	pipe_t                    nxt;
	logic signed [WIDE_W-1:0] prod;

	// stage takes a beat when empty or when downstream drains it
	assign cmd.ready = !valid_s1 || ready_i;

	// signed product and magnitudes for the restoring divider
	always_comb begin
		prod     = WIDE_W'(cmd.operand_a) * WIDE_W'(cmd.operand_b);
		nxt.op   = op_t'(cmd.operation);
		nxt.md   = cmd.modifier;
		nxt.a    = cmd.operand_a;
		nxt.b    = cmd.operand_b;
		nxt.c    = cmd.operand_c;
		nxt.prod = prod;
		nxt.rem  = '0;
		nxt.quo  = cmd.operand_a[DATA_W-1] ? (~cmd.operand_a + 1'b1) : cmd.operand_a;
		nxt.dvs  = cmd.operand_b[DATA_W-1] ? (~cmd.operand_b + 1'b1) : cmd.operand_b;
		nxt.qneg = cmd.operand_a[DATA_W-1] ^ cmd.operand_b[DATA_W-1];
		nxt.rneg = cmd.operand_a[DATA_W-1];
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			pipe_s1 <= nxt;
		end
	end

	assign valid_o = valid_s1;
	assign data_o  = pipe_s1;

endmodule

`default_nettype wire

>>> src/s16alu_div_stage.sv
// divider stage: DIV_STEPS restoring quotient steps on the magnitudes
`timescale 1ns / 1ps
`default_nettype none

module s16alu_div_stage import s16alu_pkg::*; #(
	parameter int DIV_STEPS = DIV_STEPS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   valid_i,
	output logic        ready_o,
	input  wire pipe_t  data_i,
	output logic        valid_o,
	input  wire logic   ready_i,
	output pipe_t       data_o
);

	logic  valid_sd;
	pipe_t pipe_sd;
	pipe_t nxt;

	assign ready_o = !valid_sd || ready_i;

	// shift one dividend bit into the partial remainder per step
	always_comb begin
		logic [DATA_W:0]   shifted;
		logic [DATA_W-1:0] rem_v;
		logic [DATA_W-1:0] quo_v;
		logic              qbit;
		nxt   = data_i;
		rem_v = data_i.rem;
		quo_v = data_i.quo;
		for (int i = 0; i < DIV_STEPS; i++) begin
			shifted = {rem_v, quo_v[DATA_W-1]};
			if (shifted >= {1'b0, data_i.dvs}) begin
				rem_v = DATA_W'(shifted - {1'b0, data_i.dvs});
				qbit  = 1'b1;
			end else begin
				rem_v = shifted[DATA_W-1:0];
				qbit  = 1'b0;
			end
			quo_v = {quo_v[DATA_W-2:0], qbit};
		end
		nxt.rem = rem_v;
		nxt.quo = quo_v;
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd <= 1'b0;
		end else if (ready_o) begin
			valid_sd <= valid_i;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			pipe_sd <= nxt;
		end
	end

	assign valid_o = valid_sd;
	assign data_o  = pipe_sd;

endmodule

`default_nettype wire

>>> src/s16alu_format.sv
// last stage: operation select, type tag, status and output register
`timescale 1ns / 1ps
`default_nettype none

module s16alu_format import s16alu_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   valid_i,
	output logic        ready_o,
	input  wire pipe_t  data_i,
	s16alu_res_if.source res
);

	logic              valid_sf;
	logic [BITS_W-1:0] bits_sf;
	logic [TYPE_W-1:0] type_sf;
	status_t           status_sf;

	logic [BITS_W-1:0]        bits_n;
	logic [TYPE_W-1:0]        type_n;
	status_t                  status_n;
	logic signed [DATA_W-1:0] a, b, c;
	logic signed [DATA_W-1:0] res16;
	logic signed [DATA_W-1:0] addend;
	logic signed [WIDE_W-1:0] wide;
	logic [DATA_W:0]          diff;
	logic                     use16;
	logic                     pred;

	assign ready_o = !valid_sf || res.ready;

	// result select per operation
	always_comb begin
		a        = data_i.a;
		b        = data_i.b;
		c        = data_i.c;
		addend   = (data_i.op == OP_MAD) ? c : '0;
		wide     = data_i.prod + WIDE_W'(addend);
		diff     = (a < b) ? ({b[DATA_W-1], b} - {a[DATA_W-1], a})
			: ({a[DATA_W-1], a} - {b[DATA_W-1], b});
		res16    = '0;
		use16    = 1'b0;
		pred     = 1'b0;
		bits_n   = '0;
		type_n   = TY_S16;
		status_n = ST_OK;
		case (data_i.op)
			OP_ADD: begin
				res16 = a + b;
				use16 = 1'b1;
			end
			OP_SUB: begin
				res16 = a - b;
				use16 = 1'b1;
			end
			OP_MUL, OP_MAD: begin
				case (data_i.md)
					MD_HI: begin
						res16 = data_i.prod[WIDE_W-1:DATA_W] + addend;
						use16 = 1'b1;
					end
					MD_LO: begin
						res16 = data_i.prod[DATA_W-1:0] + addend;
						use16 = 1'b1;
					end
					MD_WIDE: begin
						bits_n = {{(BITS_W-WIDE_W){wide[WIDE_W-1]}}, wide};
						type_n = TY_S32;
					end
					default: status_n = ST_BAD_MOD;
				endcase
			end
			OP_SAD: begin
				res16 = diff[DATA_W-1:0] + c;
				use16 = 1'b1;
			end
			OP_DIV, OP_REM: begin
				if (b == '0) begin
					status_n = ST_DIV_ZERO;
				end else if (data_i.op == OP_DIV) begin
					res16 = data_i.qneg ? (~data_i.quo + 1'b1) : data_i.quo;
					use16 = 1'b1;
				end else begin
					res16 = data_i.rneg ? (~data_i.rem + 1'b1) : data_i.rem;
					use16 = 1'b1;
				end
			end
			OP_ABS: begin
				res16 = a[DATA_W-1] ? -a : a;
				use16 = 1'b1;
			end
			OP_NEG: begin
				res16 = -a;
				use16 = 1'b1;
			end
			OP_MIN: begin
				res16 = (a < b) ? a : b;
				use16 = 1'b1;
			end
			OP_MAX: begin
				res16 = (a > b) ? a : b;
				use16 = 1'b1;
			end
			OP_CVT: begin
				type_n = {1'b0, data_i.md};
				case ({1'b0, data_i.md})
					TY_U8:  bits_n = {{(BITS_W-8){1'b0}}, a[7:0]};
					TY_U16: bits_n = {{(BITS_W-DATA_W){1'b0}}, a};
					TY_U32: bits_n = {{(BITS_W-WIDE_W){1'b0}},
						{(WIDE_W-DATA_W){a[DATA_W-1]}}, a};
					TY_S8:  bits_n = {{(BITS_W-8){a[7]}}, a[7:0]};
					default: bits_n = {{(BITS_W-DATA_W){a[DATA_W-1]}}, a};
				endcase
			end
			OP_SELP: begin
				res16 = (c != '0) ? a : b;
				use16 = 1'b1;
			end
			OP_SETP: begin
				type_n = TY_PRED;
				case (data_i.md)
					CMP_EQ: pred = (a == b);
					CMP_NE: pred = (a != b);
					CMP_LT: pred = (a < b);
					CMP_LE: pred = (a <= b);
					CMP_GT: pred = (a > b);
					CMP_GE: pred = (a >= b);
					default: status_n = ST_BAD_MOD;
				endcase
				bits_n = {{(BITS_W-1){1'b0}}, pred};
			end
			default: status_n = ST_BAD_MOD;
		endcase
		// wrapped 16-bit results are sign extended
		if (use16) begin
			bits_n = {{(BITS_W-DATA_W){res16[DATA_W-1]}}, res16};
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sf <= 1'b0;
		end else if (ready_o) begin
			valid_sf <= valid_i;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			bits_sf   <= bits_n;
			type_sf   <= type_n;
			status_sf <= status_n;
		end
	end

	assign res.valid       = valid_sf;
	assign res.result_bits = bits_sf;
	assign res.result_type = type_sf;
	assign res.status      = status_sf;

endmodule

`default_nettype wire

>>> src/s16alu_checker.sv
// port-level checker of the s16 integer alu and its bind
`timescale 1ns / 1ps
`default_nettype none

module s16alu_checker import s16alu_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire logic [BITS_W-1:0] res_bits,
	input wire logic [TYPE_W-1:0] res_type,
	input wire logic [1:0]        res_status
);

	// a stalled result beat stays offered
	a_res_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// a stalled result beat keeps its payload
	a_res_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_bits) && $stable(res_type)
			&& $stable(res_status))
		else $error("result payload changed while stalled");

	// division by zero gives a zero s16 result
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_DIV_ZERO |-> res_bits == '0 && res_type == TY_S16)
		else $error("division by zero result not cleared");

	// an invalid modifier gives a zero pattern
	a_bad_mod: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_BAD_MOD |-> res_bits == '0
			&& (res_type == TY_S16 || res_type == TY_PRED))
		else $error("invalid modifier result not cleared");

	// a predicate is a single bit
	a_pred_bit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_type == TY_PRED |-> res_bits[BITS_W-1:1] == '0)
		else $error("predicate result wider than one bit");

endmodule

bind s16_integer_alu_top s16alu_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_bits   (res.result_bits),
	.res_type   (res.result_type),
	.res_status (res.status)
);

`default_nettype wire

>>> bench/s16_integer_alu_top_tb.sv
// self-checking testbench of the signed 16-bit integer alu with random stalls on both channels
`timescale 1ns / 1ps

module s16_integer_alu_top_tb;
	import s16alu_pkg::*;

	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 24;
	localparam int          LIMIT        = 200000;
	localparam int          IDLE_PCT     = 34;
	localparam int          REPORT_MAX   = 10;
	localparam logic [3:0]  OP_SPARE_LO  = 4'd14;
	localparam logic [3:0]  OP_SPARE_HI  = 4'd15;
	localparam logic [MOD_W-1:0] MD_NONE = 3'd0;
	localparam logic [MOD_W-1:0] MD_BAD  = 3'd7;
	localparam logic [MOD_W-1:0] CMP_BAD = 3'd6;
	localparam logic [MOD_W-1:0] MD_TOP  = 3'd7;

	typedef struct {
		logic [3:0]               op;
		logic [MOD_W-1:0]         md;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic signed [DATA_W-1:0] c;
	} alu_instr_t;

	typedef struct {
		logic [BITS_W-1:0] bits;
		logic [TYPE_W-1:0] rtype;
		logic [1:0]        status;
	} alu_result_t;

	// computes the result of each issued instruction and matches it against returned beats
	class alu_result_tracker;
		alu_result_t due_q[$];
		int unsigned fails;

		function logic [63:0] sx16(int v);
			return {{48{v[15]}}, v[15:0]};
		endfunction

		function logic [63:0] sx32(int v);
			return {{32{v[31]}}, v[31:0]};
		endfunction

		function alu_result_t compute(alu_instr_t x);
			alu_result_t r;
			int a, b, c, prod, hi, lo, add, mag;
			a = int'(x.a);
			b = int'(x.b);
			c = int'(x.c);
			r.bits = '0;
			r.rtype = TY_S16;
			r.status = ST_OK;
			prod = a * b;
			hi = int'($signed(prod[31:16]));
			lo = int'($signed(prod[15:0]));
			case (x.op)
				OP_ADD: r.bits = sx16(a + b);
				OP_SUB: r.bits = sx16(a - b);
				OP_MUL, OP_MAD: begin
					add = (x.op == OP_MAD) ? c : 0;
					case (x.md)
						MD_HI: r.bits = sx16(hi + add);
						MD_LO: r.bits = sx16(lo + add);
						MD_WIDE: begin
							r.bits = sx32(prod + add);
							r.rtype = TY_S32;
						end
						default: r.status = ST_BAD_MOD;
					endcase
				end
				OP_SAD: begin
					mag = (a < b) ? b - a : a - b;
					r.bits = sx16(mag + c);
				end
				OP_DIV, OP_REM: begin
					if (b == 0) begin
						r.status = ST_DIV_ZERO;
					end else begin
						r.bits = sx16((x.op == OP_DIV) ? a / b : a % b);
					end
				end
				OP_ABS: r.bits = sx16((a < 0) ? -a : a);
				OP_NEG: r.bits = sx16(-a);
				OP_MIN: r.bits = sx16((a < b) ? a : b);
				OP_MAX: r.bits = sx16((a > b) ? a : b);
				OP_CVT: begin
					// truncate or extend to the target type
					r.rtype = {1'b0, x.md};
					case (r.rtype)
						TY_U8:   r.bits = {56'b0, a[7:0]};
						TY_U16:  r.bits = {48'b0, a[15:0]};
						TY_U32:  r.bits = {32'b0, a[31:0]};
						TY_S8:   r.bits = {{56{a[7]}}, a[7:0]};
						default: r.bits = sx16(a);
					endcase
				end
				OP_SELP: r.bits = sx16((c != 0) ? a : b);
				OP_SETP: begin
					r.rtype = TY_PRED;
					case (x.md)
						CMP_EQ:  r.bits = {63'b0, a == b};
						CMP_NE:  r.bits = {63'b0, a != b};
						CMP_LT:  r.bits = {63'b0, a < b};
						CMP_LE:  r.bits = {63'b0, a <= b};
						CMP_GT:  r.bits = {63'b0, a > b};
						CMP_GE:  r.bits = {63'b0, a >= b};
						default: r.status = ST_BAD_MOD;
					endcase
				end
				default: r.status = ST_BAD_MOD;
			endcase
			return r;
		endfunction

		function void note_issue(alu_instr_t x);
			due_q.push_back(compute(x));
		endfunction

		function void check_result(alu_result_t got);
			alu_result_t want;
			if (due_q.size() == 0) begin
				fails++;
				if (fails <= REPORT_MAX)
					$display("%0t: unexpected result beat bits=%h type=%0d status=%0d",
						$time, got.bits, got.rtype, got.status);
				return;
			end
			want = due_q.pop_front();
			if (got.bits !== want.bits || got.rtype !== want.rtype
				|| got.status !== want.status) begin
				fails++;
				if (fails <= REPORT_MAX)
					$display("%0t: mismatch want bits=%h type=%0d status=%0d, got bits=%h type=%0d status=%0d",
						$time, want.bits, want.rtype, want.status,
						got.bits, got.rtype, got.status);
			end
		endfunction

		function int unsigned pending();
			return due_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;
	bit   hold_arm;
	bit   hold_taken;
	int   hold_left;
	int   cycles;

	alu_result_tracker tracker;

	s16alu_cmd_if cmd ();
	s16alu_res_if res ();

	s16_integer_alu_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off, and a stretch always ready
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res.ready <= 1'b0;
		end else if (hold_arm && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
			res.ready <= 1'b0;
		end else if (quiet) begin
			res.ready <= 1'b1;
		end else begin
			res.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// note every accepted command beat
	always @(posedge clk) begin
		alu_instr_t x;
		if (arst_n && cmd.valid && cmd.ready) begin
			x.op = cmd.operation;
			x.md = cmd.modifier;
			x.a = cmd.operand_a;
			x.b = cmd.operand_b;
			x.c = cmd.operand_c;
			tracker.note_issue(x);
		end
	end

	// check every accepted result beat
	always @(posedge clk) begin
		alu_result_t got;
		if (arst_n && res.valid && res.ready) begin
			got.bits = res.result_bits;
			got.rtype = res.result_type;
			got.status = res.status;
			tracker.check_result(got);
		end
	end

	function automatic alu_instr_t mk(logic [3:0] op, logic [MOD_W-1:0] md,
		logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b,
		logic signed [DATA_W-1:0] c);
		alu_instr_t x;
		x.op = op;
		x.md = md;
		x.a = a;
		x.b = b;
		x.c = c;
		return x;
	endfunction

	// operand mix: corner values, small values, full range
	function automatic logic signed [DATA_W-1:0] rand_operand();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0:       v = 16'sh8000;
					1:       v = -16'sd1;
					2:       v = 16'sd0;
					3:       v = 16'sd1;
					default: v = 16'sh7fff;
				endcase
			end
			1:       v = DATA_W'($urandom_range(0, 16) - 8);
			default: v = DATA_W'($urandom_range(0, 65535));
		endcase
		return v;
	endfunction

	function automatic alu_instr_t rand_instr();
		alu_instr_t x;
		if ($urandom_range(0, 49) == 0)
			x.op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		else
			x.op = 4'($urandom_range(OP_ADD, OP_SETP));
		x.md = MOD_W'($urandom_range(MD_NONE, MD_TOP));
		x.a = rand_operand();
		x.b = rand_operand();
		x.c = rand_operand();
		case (x.op)
			OP_MUL, OP_MAD: begin
				if ($urandom_range(0, 7) != 0) x.md = MOD_W'($urandom_range(MD_HI, MD_WIDE));
			end
			OP_SETP: begin
				if ($urandom_range(0, 7) != 0) x.md = MOD_W'($urandom_range(CMP_EQ, CMP_GE));
				if ($urandom_range(0, 3) == 0) x.b = x.a;
			end
			OP_DIV, OP_REM: begin
				if ($urandom_range(0, 9) == 0) x.b = '0;
			end
			OP_MIN, OP_MAX, OP_SAD: begin
				if ($urandom_range(0, 4) == 0) x.b = x.a;
			end
			OP_SELP: begin
				if ($urandom_range(0, 1) == 0) x.c = '0;
			end
			default: ;
		endcase
		return x;
	endfunction

	// offer one command beat, with random gaps ahead of it when allowed
	task automatic send_instr(input alu_instr_t x, input bit idle_ok);
		while (idle_ok && !quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.operation <= x.op;
		cmd.modifier <= x.md;
		cmd.operand_a <= x.a;
		cmd.operand_b <= x.b;
		cmd.operand_c <= x.c;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
	endtask

	task automatic send_random(input int n, input bit idle_ok);
		repeat (n) send_instr(rand_instr(), idle_ok);
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		cycles = 0;
		quiet = 1'b0;
		hold_arm = 1'b0;
		hold_taken = 1'b0;
		hold_left = 0;
		cmd.valid = 1'b0;
		cmd.operation = '0;
		cmd.modifier = '0;
		cmd.operand_a = '0;
		cmd.operand_b = '0;
		cmd.operand_c = '0;
		res.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: wrap, product forms, bad modifiers, divide corners, cvt targets, an unused operation
		send_instr(mk(OP_ADD, MD_NONE, 16'sh7fff, 16'sd1, 16'sd0), 1'b1);
		send_instr(mk(OP_SUB, MD_NONE, 16'sh8000, 16'sd1, 16'sd0), 1'b1);
		send_instr(mk(OP_MUL, MD_HI, 16'sh8000, 16'sh8000, 16'sd0), 1'b1);
		send_instr(mk(OP_MUL, MD_LO, 16'sh7fff, 16'sh7fff, 16'sd0), 1'b1);
		send_instr(mk(OP_MUL, MD_WIDE, 16'sh8000, 16'sh8000, 16'sd0), 1'b1);
		send_instr(mk(OP_MAD, MD_HI, 16'sh7fff, 16'sh8000, 16'sh7fff), 1'b1);
		send_instr(mk(OP_MAD, MD_WIDE, 16'sh8000, 16'sh7fff, 16'sh8000), 1'b1);
		send_instr(mk(OP_MUL, MD_BAD, 16'sd3, 16'sd5, 16'sd0), 1'b1);
		send_instr(mk(OP_SAD, MD_NONE, 16'sh8000, 16'sh7fff, 16'sh7fff), 1'b1);
		send_instr(mk(OP_DIV, MD_NONE, 16'sh8000, -16'sd1, 16'sd0), 1'b1);
		send_instr(mk(OP_REM, MD_NONE, 16'sh8000, -16'sd1, 16'sd0), 1'b1);
		send_instr(mk(OP_DIV, MD_NONE, 16'sd7, 16'sd0, 16'sd0), 1'b1);
		send_instr(mk(OP_REM, MD_NONE, -16'sd7, 16'sd0, 16'sd0), 1'b1);
		send_instr(mk(OP_REM, MD_NONE, -16'sd7, 16'sd2, 16'sd0), 1'b1);
		send_instr(mk(OP_ABS, MD_NONE, 16'sh8000, 16'sd0, 16'sd0), 1'b1);
		send_instr(mk(OP_NEG, MD_NONE, 16'sh8000, 16'sd0, 16'sd0), 1'b1);
		send_instr(mk(OP_MIN, MD_NONE, 16'sh8000, 16'sh7fff, 16'sd0), 1'b1);
		send_instr(mk(OP_MAX, MD_NONE, 16'sh8000, 16'sh7fff, 16'sd0), 1'b1);
		for (int t = TY_S16; t <= TY_S64; t++)
			send_instr(mk(OP_CVT, t[MOD_W-1:0], 16'sh8081, 16'sd0, 16'sd0), 1'b1);
		send_instr(mk(OP_SELP, MD_NONE, 16'sd11, 16'sd22, 16'sd0), 1'b1);
		send_instr(mk(OP_SETP, CMP_LT, 16'sh8000, 16'sh7fff, 16'sd0), 1'b1);
		send_instr(mk(OP_SETP, CMP_BAD, 16'sd1, 16'sd1, 16'sd0), 1'b1);
		send_instr(mk(OP_SPARE_HI, MD_NONE, 16'sd1, 16'sd2, 16'sd3), 1'b1);

		// sender pauses until the pipe is empty
		wait_drained();

		// random traffic with gaps on both sides
		send_random(600, 1'b1);

		// receiver holds off while beats keep coming, so the pipe fills and stalls
		hold_arm = 1'b1;
		send_random(100, 1'b0);
		wait_drained();

		// stretch with no gaps at all
		quiet = 1'b1;
		send_random(300, 1'b1);
		quiet = 1'b0;

		send_random(575, 1'b1);

		// let the pipe drain, then watch for stray beats
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.fails == 0 && tracker.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
